[hdl/pibtt_pkg.sv]
// Package with types and constants for the point-in-box trigger table.
package pibtt_pkg;

    localparam int MAX_BOXES = 32;
    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int ACC_W = 32 + CNT_W;
    localparam int QDEPTH = 2;
    localparam logic [31:0] NO_HANDLE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_INACTIVE = 2'd0,
        KIND_REPEAT   = 2'd1,
        KIND_ONCE     = 2'd2,
        KIND_PUSH     = 2'd3
    } box_kind_t;

    typedef enum logic [1:0] {
        RES_EVENT = 2'd0,
        RES_PUSH  = 2'd1,
        RES_ACK   = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST
    } exec_state_t;

    typedef struct packed {
        opcode_t            op;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] lz;
        logic signed [31:0] hx;
        logic signed [31:0] hy;
        logic signed [31:0] hz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        box_kind_t          kind;
        logic [31:0]        tag;
    } cmd_t;

    typedef struct packed {
        result_kind_t       kind;
        logic [31:0]        code;
        logic [31:0]        handle;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic               acc;
        logic               last;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'(32'sh7FFF_FFFF));
        lo = ACC_W'(signed'(32'sh8000_0000));
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

[hdl/pibtt_front.sv]
// Front end: accepts items, drops unused opcodes, queues commands.
module pibtt_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pibtt_pkg::cmd_t   cmd_in,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output pibtt_pkg::cmd_t   cmd_out
);

    pibtt_pkg::cmd_t q_mem [pibtt_pkg::QDEPTH];
    logic [0:0] wp_reg;
    logic [0:0] rp_reg;
    logic [1:0] cnt_reg;
    logic       wr;
    logic       rd;

    assign full = (cnt_reg == 2'(pibtt_pkg::QDEPTH));
    assign wr = push && !full && (cmd_in.op != pibtt_pkg::OP_NONE);
    assign rd = cmd_take && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_out = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            q_mem[wp_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

[hdl/pibtt_back.sv]
// Back end: box table, scan sequencer and result register.
module pibtt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_take,
    input  pibtt_pkg::cmd_t  cmd,
    output logic             res_valid,
    input  logic             res_take,
    output pibtt_pkg::res_t  res
);

    localparam int IW = pibtt_pkg::IDX_W;
    localparam int CW = pibtt_pkg::CNT_W;
    localparam int AW = pibtt_pkg::ACC_W;

    logic [32*9+2+32-1:0] box_mem [pibtt_pkg::MAX_BOXES];
    logic [32*9+2+32-1:0] rd_reg;
    logic [pibtt_pkg::MAX_BOXES-1:0] fired_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          rd_ok_reg;
    logic [IW-1:0] rd_idx_reg;
    pibtt_pkg::exec_state_t state_reg;
    pibtt_pkg::exec_state_t state_next;
    pibtt_pkg::cmd_t cur_reg;
    logic signed [AW-1:0] sx_reg;
    logic signed [AW-1:0] sy_reg;
    logic signed [AW-1:0] sz_reg;
    logic          out_full_reg;
    pibtt_pkg::res_t out_reg;

    logic signed [31:0] b_lx, b_ly, b_lz, b_hx, b_hy, b_hz, b_px, b_py, b_pz;
    pibtt_pkg::box_kind_t b_kind;
    logic [31:0] b_ev;
    logic in_box;
    logic fired_b;
    logic ev_hit;
    logic slot_free;
    logic rd_en;
    logic [IW-1:0] rd_addr;
    logic start;
    logic emit;
    pibtt_pkg::res_t emit_res;

    assign {b_lx, b_ly, b_lz, b_hx, b_hy, b_hz, b_px, b_py, b_pz, b_kind, b_ev} = rd_reg;
    assign slot_free = !out_full_reg || res_take;
    assign res_valid = out_full_reg;
    assign res = out_reg;

    assign in_box = (cur_reg.lx >= b_lx) && (cur_reg.lx <= b_hx)
                 && (cur_reg.ly >= b_ly) && (cur_reg.ly <= b_hy)
                 && (cur_reg.lz >= b_lz) && (cur_reg.lz <= b_hz);
    assign fired_b = fired_reg[rd_idx_reg];
    assign ev_hit = rd_ok_reg && in_box
                 && (b_kind == pibtt_pkg::KIND_REPEAT
                     || (b_kind == pibtt_pkg::KIND_ONCE && !fired_b));

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd_take = 1'b0;
        start = 1'b0;
        emit = 1'b0;
        emit_res = '0;
        rd_en = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        unique case (state_reg)
            pibtt_pkg::ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_take = 1'b1;
                    if (cmd.op == pibtt_pkg::OP_UPDATE)
                    begin
                        start = 1'b1;
                        state_next = pibtt_pkg::ST_SCAN;
                        idx_next = '0;
                    end
                    else
                    begin
                        emit = 1'b1;
                        emit_res.kind = pibtt_pkg::RES_ACK;
                        emit_res.acc = (cmd.op == pibtt_pkg::OP_CLEAR)
                                    || (count_reg < CW'(pibtt_pkg::MAX_BOXES));
                        emit_res.last = 1'b1;
                    end
                end
            end
            pibtt_pkg::ST_SCAN:
            begin
                if (!(ev_hit && cur_reg.tag != pibtt_pkg::NO_HANDLE) || slot_free)
                begin
                    if (ev_hit && cur_reg.tag != pibtt_pkg::NO_HANDLE)
                    begin
                        emit = 1'b1;
                        emit_res.kind = pibtt_pkg::RES_EVENT;
                        emit_res.code = b_ev;
                        emit_res.handle = cur_reg.tag;
                        emit_res.acc = 1'b1;
                    end
                    if (idx_reg < count_reg)
                    begin
                        rd_en = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                        state_next = pibtt_pkg::ST_LAST;
                end
            end
            pibtt_pkg::ST_LAST:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    emit_res.kind = pibtt_pkg::RES_PUSH;
                    emit_res.sx = pibtt_pkg::sat32(sx_reg);
                    emit_res.sy = pibtt_pkg::sat32(sy_reg);
                    emit_res.sz = pibtt_pkg::sat32(sz_reg);
                    emit_res.acc = 1'b1;
                    emit_res.last = 1'b1;
                    state_next = pibtt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pibtt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.op == pibtt_pkg::OP_ADD && count_reg < CW'(pibtt_pkg::MAX_BOXES))
            box_mem[count_reg[IW-1:0]] <= {cmd.lx, cmd.ly, cmd.lz, cmd.hx, cmd.hy, cmd.hz,
                                           cmd.px, cmd.py, cmd.pz, cmd.kind, cmd.tag};
        if (rd_en)
            rd_reg <= box_mem[rd_addr];
        if (start)
            cur_reg <= cmd;
        if (emit)
            out_reg <= emit_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pibtt_pkg::ST_IDLE;
            idx_reg <= '0;
            count_reg <= '0;
            fired_reg <= '0;
            rd_ok_reg <= 1'b0;
            rd_idx_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            if (emit)
                out_full_reg <= 1'b1;
            else if (res_take)
                out_full_reg <= 1'b0;
            if (cmd_take && cmd.op == pibtt_pkg::OP_CLEAR)
            begin
                count_reg <= '0;
                fired_reg <= '0;
            end
            else if (cmd_take && cmd.op == pibtt_pkg::OP_ADD
                     && count_reg < CW'(pibtt_pkg::MAX_BOXES))
            begin
                count_reg <= count_reg + 1'b1;
                fired_reg[count_reg[IW-1:0]] <= 1'b0;
            end
            if (start)
            begin
                sx_reg <= '0;
                sy_reg <= '0;
                sz_reg <= '0;
                rd_ok_reg <= 1'b0;
            end
            else if (state_reg == pibtt_pkg::ST_SCAN && state_next != state_reg)
                rd_ok_reg <= 1'b0;
            else if (state_reg == pibtt_pkg::ST_SCAN && rd_en)
            begin
                rd_ok_reg <= 1'b1;
                rd_idx_reg <= rd_addr;
            end
            if (state_reg == pibtt_pkg::ST_SCAN && (rd_en || state_next != state_reg)
                && rd_ok_reg && in_box)
            begin
                if (b_kind == pibtt_pkg::KIND_PUSH)
                begin
                    sx_reg <= sx_reg + AW'(b_px);
                    sy_reg <= sy_reg + AW'(b_py);
                    sz_reg <= sz_reg + AW'(b_pz);
                end
                if (ev_hit)
                    fired_reg[rd_idx_reg] <= 1'b1;
            end
        end
    end

endmodule

[hdl/point_in_box_trigger_table.sv]
// Top level of the point-in-box trigger table.
// An add or clear gives a registered acknowledge item once the back end takes it from the command queue.
// An update reads the stored boxes from the box memory, one per cycle unless an event item waits on a full result.
// Up to two items wait in the command queue while an update runs.
// Asynchronous active-low reset empties the table, command queue and result register.
module point_in_box_trigger_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic signed [31:0] point_or_low_x,
    input  logic signed [31:0] point_or_low_y,
    input  logic signed [31:0] point_or_low_z,
    input  logic signed [31:0] high_x,
    input  logic signed [31:0] high_y,
    input  logic signed [31:0] high_z,
    input  logic signed [31:0] push_in_x,
    input  logic signed [31:0] push_in_y,
    input  logic signed [31:0] push_in_z,
    input  logic [1:0]  box_kind,
    input  logic [31:0] tag,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [31:0] event_code,
    output logic [31:0] target_handle,
    output logic signed [31:0] push_sum_x,
    output logic signed [31:0] push_sum_y,
    output logic signed [31:0] push_sum_z,
    output logic        accepted,
    output logic        last
);

    pibtt_pkg::cmd_t cmd_in;
    pibtt_pkg::cmd_t cmd_q;
    pibtt_pkg::res_t res;
    logic cmd_valid;
    logic cmd_take;
    logic res_valid;

    assign cmd_in = '{op: pibtt_pkg::opcode_t'(opcode), lx: point_or_low_x,
                      ly: point_or_low_y, lz: point_or_low_z, hx: high_x, hy: high_y,
                      hz: high_z, px: push_in_x, py: push_in_y, pz: push_in_z,
                      kind: pibtt_pkg::box_kind_t'(box_kind), tag: tag};

    pibtt_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd_in(cmd_in),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_out(cmd_q)
    );

    pibtt_back u_back
    (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd_q), .res_valid(res_valid), .res_take(pop && res_valid), .res(res)
    );

    assign empty = !res_valid;
    assign result_kind = res.kind;
    assign event_code = res.code;
    assign target_handle = res.handle;
    assign push_sum_x = res.sx;
    assign push_sum_y = res.sy;
    assign push_sum_z = res.sz;
    assign accepted = res.acc;
    assign last = res.last;

endmodule

[hdl/pibtt_checker.sv]
// Port-level checker for the point-in-box trigger table, with its bind.
module pibtt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  result_kind,
    input logic [31:0] event_code,
    input logic        accepted,
    input logic        last
);

    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result_kind == pibtt_pkg::RES_EVENT || result_kind == pibtt_pkg::RES_PUSH
                    || result_kind == pibtt_pkg::RES_ACK))
        else $error("bad result kind");

    a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == pibtt_pkg::RES_EVENT) |-> (!last && accepted))
        else $error("event item marked last");

    a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != pibtt_pkg::RES_EVENT) |-> last)
        else $error("final item without last");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(event_code) && $stable(result_kind)))
        else $error("waiting item changed");

endmodule

bind point_in_box_trigger_table pibtt_checker u_pibtt_checker
(
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .result_kind(result_kind),
    .event_code(event_code), .accepted(accepted), .last(last)
);

[verif/point_in_box_trigger_table_checker.sv]
// Checker that predicts and compares every result of the point-in-box trigger table.
module point_in_box_trigger_table_checker
    import pibtt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [1:0]        opcode,
    input  logic [31:0]       point_or_low_x,
    input  logic [31:0]       point_or_low_y,
    input  logic [31:0]       point_or_low_z,
    input  logic [31:0]       high_x,
    input  logic [31:0]       high_y,
    input  logic [31:0]       high_z,
    input  logic [31:0]       push_in_x,
    input  logic [31:0]       push_in_y,
    input  logic [31:0]       push_in_z,
    input  logic [1:0]        box_kind,
    input  logic [31:0]       tag,
    input  logic              empty,
    input  logic              pop,
    input  logic [1:0]        result_kind,
    input  logic [31:0]       event_code,
    input  logic [31:0]       target_handle,
    input  logic [31:0]       push_sum_x,
    input  logic [31:0]       push_sum_y,
    input  logic [31:0]       push_sum_z,
    input  logic              accepted,
    input  logic              last,
    output int                fail_count,
    output int                pending_count
);

    int unsigned box_count;
    logic signed [31:0] lo_x[MAX_BOXES], lo_y[MAX_BOXES], lo_z[MAX_BOXES];
    logic signed [31:0] hi_x[MAX_BOXES], hi_y[MAX_BOXES], hi_z[MAX_BOXES];
    logic signed [31:0] vec_x[MAX_BOXES], vec_y[MAX_BOXES], vec_z[MAX_BOXES];
    box_kind_t kinds[MAX_BOXES];
    logic [31:0] codes[MAX_BOXES];
    logic fired[MAX_BOXES];
    res_t expected_results[$];

    initial
    begin
        fail_count = 0;
        box_count = 0;
        foreach (fired[i]) fired[i] = 1'b0;
    end

    assign pending_count = expected_results.size();

    function automatic logic signed [31:0] clamp(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic res_t make_result(input result_kind_t k, input logic [31:0] c,
                                         input logic [31:0] h, input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [31:0] z,
                                         input logic a, input logic l);
        res_t r;
        r.kind = k; r.code = c; r.handle = h; r.sx = x; r.sy = y; r.sz = z;
        r.acc = a; r.last = l;
        return r;
    endfunction

    task automatic predict_item();
        logic signed [31:0] px, py, pz;
        longint sum_x, sum_y, sum_z;
        logic hit;
        px = point_or_low_x; py = point_or_low_y; pz = point_or_low_z;
        case (opcode_t'(opcode))
            OP_ADD:
            begin
                if (box_count >= MAX_BOXES)
                    expected_results.push_back(make_result(RES_ACK, 0, 0, 0, 0, 0, 0, 1));
                else
                begin
                    lo_x[box_count] = px; lo_y[box_count] = py; lo_z[box_count] = pz;
                    hi_x[box_count] = high_x; hi_y[box_count] = high_y;
                    hi_z[box_count] = high_z;
                    vec_x[box_count] = push_in_x; vec_y[box_count] = push_in_y;
                    vec_z[box_count] = push_in_z;
                    kinds[box_count] = box_kind_t'(box_kind);
                    codes[box_count] = tag;
                    fired[box_count] = 1'b0;
                    box_count++;
                    expected_results.push_back(make_result(RES_ACK, 0, 0, 0, 0, 0, 1, 1));
                end
            end
            OP_CLEAR:
            begin
                box_count = 0;
                foreach (fired[i]) fired[i] = 1'b0;
                expected_results.push_back(make_result(RES_ACK, 0, 0, 0, 0, 0, 1, 1));
            end
            OP_UPDATE:
            begin
                sum_x = 0; sum_y = 0; sum_z = 0;
                for (int i = 0; i < box_count; i++)
                begin
                    hit = px >= lo_x[i] && px <= hi_x[i] && py >= lo_y[i] && py <= hi_y[i]
                          && pz >= lo_z[i] && pz <= hi_z[i];
                    if (kinds[i] == KIND_INACTIVE || !hit)
                        continue;
                    if (kinds[i] == KIND_PUSH)
                    begin
                        sum_x += vec_x[i]; sum_y += vec_y[i]; sum_z += vec_z[i];
                    end
                    else if (!(kinds[i] == KIND_ONCE && fired[i]))
                    begin
                        fired[i] = 1'b1;
                        if (tag != NO_HANDLE)
                            expected_results.push_back(
                                make_result(RES_EVENT, codes[i], tag, 0, 0, 0, 1, 0));
                    end
                end
                expected_results.push_back(make_result(RES_PUSH, 0, 0, clamp(sum_x),
                                                       clamp(sum_y), clamp(sum_z), 1, 1));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_result();
        res_t w;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected item", 32'(result_kind), 32'd0);
            return;
        end
        w = expected_results.pop_front();
        if (result_kind !== w.kind)
            report_mismatch("result_kind", 32'(result_kind), 32'(w.kind));
        if (event_code !== w.code) report_mismatch("event_code", event_code, w.code);
        if (target_handle !== w.handle)
            report_mismatch("target_handle", target_handle, w.handle);
        if (push_sum_x !== w.sx) report_mismatch("push_sum_x", push_sum_x, w.sx);
        if (push_sum_y !== w.sy) report_mismatch("push_sum_y", push_sum_y, w.sy);
        if (push_sum_z !== w.sz) report_mismatch("push_sum_z", push_sum_z, w.sz);
        if (accepted !== w.acc) report_mismatch("accepted", 32'(accepted), 32'(w.acc));
        if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_result();
            if (push && !full)
                predict_item();
        end
    end

endmodule

[verif/point_in_box_trigger_table_tb.sv]
// Testbench top that drives the point-in-box trigger table and gives the verdict.
module point_in_box_trigger_table_tb;
    import pibtt_pkg::*;

    logic clk, rst_n, push, full, empty, pop, accepted, last;
    logic [1:0] opcode, box_kind, result_kind;
    logic signed [31:0] point_or_low_x, point_or_low_y, point_or_low_z;
    logic signed [31:0] high_x, high_y, high_z, push_in_x, push_in_y, push_in_z;
    logic [31:0] tag, event_code, target_handle;
    logic signed [31:0] push_sum_x, push_sum_y, push_sum_z;
    int fail_count, pending_count;
    int send_idle_pct, stall_pct;

    point_in_box_trigger_table u_top (.*);

    point_in_box_trigger_table_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(40)) - 20;
        endcase
    endfunction

    task automatic send_item(input opcode_t op, input logic signed [31:0] lx, ly, lz,
                             input logic signed [31:0] hx, hy, hz, vx, vy, vz,
                             input box_kind_t k, input logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        point_or_low_x <= lx; point_or_low_y <= ly; point_or_low_z <= lz;
        high_x <= hx; high_y <= hy; high_z <= hz;
        push_in_x <= vx; push_in_y <= vy; push_in_z <= vz;
        box_kind <= k; tag <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_box();
        logic signed [31:0] ax, ay, az;
        ax = pick_coord(); ay = pick_coord(); az = pick_coord();
        send_item(OP_ADD, ax, ay, az,
                  ($urandom_range(9) == 0) ? pick_coord() : ax + $urandom_range(30),
                  ($urandom_range(9) == 0) ? pick_coord() : ay + $urandom_range(30),
                  ($urandom_range(9) == 0) ? pick_coord() : az + $urandom_range(30),
                  pick_coord(), pick_coord(), pick_coord(),
                  box_kind_t'($urandom_range(3)), $urandom);
    endtask

    task automatic send_random_update();
        send_item(OP_UPDATE, pick_coord(), pick_coord(), pick_coord(), $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, box_kind_t'($urandom_range(3)),
                  ($urandom_range(4) == 0) ? NO_HANDLE : $urandom);
    endtask

    task automatic send_phase(input int count);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(19))
                0: send_item(OP_CLEAR, $urandom, $urandom, $urandom, 0, 0, 0, 0, 0, 0,
                             KIND_INACTIVE, $urandom);
                1: send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, 0, 0, 0, 0,
                             0, KIND_PUSH, $urandom);
                2, 3, 4, 5, 6, 7, 8: send_random_box();
                default: send_random_update();
            endcase
        end
    endtask

    initial
    begin
        push = 1'b0; pop = 1'b0; opcode = OP_NONE; box_kind = KIND_INACTIVE;
        point_or_low_x = 0; point_or_low_y = 0; point_or_low_z = 0;
        high_x = 0; high_y = 0; high_z = 0; push_in_x = 0; push_in_y = 0; push_in_z = 0;
        tag = 0; send_idle_pct = 0; stall_pct = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full-range boxes, saturating pushes, once and repeat events, and no handle.
        send_item(OP_ADD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 5,
                  KIND_PUSH, 0);
        send_item(OP_ADD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, -5,
                  KIND_PUSH, 0);
        send_item(OP_ADD, 0, 0, 0, 10, 10, 10, 0, 0, 0, KIND_ONCE, 32'hFFFF_FFFF);
        send_item(OP_ADD, 10, 10, 10, 10, 10, 10, 0, 0, 0, KIND_REPEAT, 32'h1234_5678);
        send_item(OP_ADD, 0, 0, 0, 10, 10, 10, 0, 0, 0, KIND_INACTIVE, 7);
        send_item(OP_UPDATE, 10, 10, 10, 0, 0, 0, 0, 0, 0, KIND_INACTIVE, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 10, 10, 10, 0, 0, 0, 0, 0, 0, KIND_INACTIVE, 0);
        send_item(OP_UPDATE, 11, 10, 10, 0, 0, 0, 0, 0, 0, KIND_INACTIVE, 32'h0BAD_CAFE);
        send_item(OP_UPDATE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0,
                  KIND_INACTIVE, 3);
        send_item(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_INACTIVE, 0);
        for (int n = 0; n < MAX_BOXES; n++)
            send_item(OP_ADD, -1, -1, -1, 1, 1, 1, 32'h7000_0000, -32'sh7000_0000, n,
                      (n % 2) ? KIND_PUSH : KIND_ONCE, n);
        send_item(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_INACTIVE, 9);
        send_item(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_INACTIVE, 9);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, KIND_INACTIVE, 0);

        send_phase(34);
        send_idle_pct = 78;
        send_phase(34);
        send_idle_pct = 0; stall_pct = 78;
        send_phase(34);
        send_idle_pct = 16; stall_pct = 16;
        send_phase(34);
        push <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
